### design/brq_pkg.sv
// Shared types, constants and register codes for the bias/requantize output stage.
`timescale 1ns / 1ps

package brq_pkg;

  localparam int NUM_COLUMNS = 64;
  localparam int COL_W       = 6;
  localparam int ACC_W       = 64;
  localparam int WORD_W      = 32;
  localparam int SHIFT_W     = 7;
  localparam int TBITS_W     = 6;
  localparam int PROD_W      = 128;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 6;

  // Only columns reachable through the column field get storage.
  localparam int MEM_DEPTH = (NUM_COLUMNS < (1 << COL_W)) ? NUM_COLUMNS : (1 << COL_W);
  localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  localparam int IN_DATA_W  = 144;
  localparam int OUT_DATA_W = 72;

  typedef enum logic {
    KIND_DATA  = 1'b0,
    KIND_WRITE = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIAS_ENABLE      = 3'd0,
    REG_REQUANT_ENABLE   = 3'd1,
    REG_ROUND_ENABLE     = 3'd2,
    REG_TARGET_SIGNED    = 3'd3,
    REG_TGT_WIDTH        = 3'd4,
    REG_BIAS_PER_COLUMN  = 3'd5,
    REG_SCALE_PER_COLUMN = 3'd6,
    REG_SHIFT_PER_COLUMN = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic               bias_enable;
    logic               requant_enable;
    logic               round_enable;
    logic               target_signed;
    logic [TBITS_W-1:0] tgt_width;
    logic               bias_per_column;
    logic               scale_per_column;
    logic               shift_per_column;
  } cfg_t;

  // One column's parameter entry as stored in the table memory.
  typedef struct packed {
    logic signed [WORD_W-1:0] bias;
    logic signed [WORD_W-1:0] scale;
    logic [SHIFT_W-1:0]       shift;
  } entry_t;

endpackage

### design/brq_table.sv
// Column parameter table: synchronous memory with one write and one read port plus an entry-zero shadow.
`timescale 1ns / 1ps

module brq_table
  import brq_pkg::*;
(
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  entry_t            wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output entry_t            rd_data,
  output entry_t            zero_data
);

  entry_t mem [MEM_DEPTH];
  entry_t zero_entry_r;
  entry_t rd_data_r;
  entry_t zero_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Keep a copy of entry zero so shared mode needs no second read port.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == '0)) begin
      zero_entry_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r   <= mem[rd_addr];
      zero_data_r <= zero_entry_r;
    end
  end

  assign rd_data   = rd_data_r;
  assign zero_data = zero_data_r;

endmodule

### design/brq_requant.sv
// Requantize pipeline: multiply, round, arithmetic shift, clamp and output register.
`timescale 1ns / 1ps

module brq_requant
  import brq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  cfg_t                    cfg,
  input  logic                    s_valid,
  output logic                    s_ready,
  input  logic [COL_W-1:0]        s_column,
  input  logic signed [ACC_W-1:0] s_value,
  input  logic signed [WORD_W-1:0] s_scale,
  input  logic [SHIFT_W-1:0]      s_shift,
  output logic                    m_valid,
  input  logic                    m_ready,
  output logic [COL_W-1:0]        m_column,
  output logic signed [ACC_W-1:0] m_value
);

  // Stage valids, in order a, b, c, d, e, output.
  logic a_vld_r, b_vld_r, c_vld_r, d_vld_r, e_vld_r, o_vld_r;
  logic a_en, b_en, c_en, d_en, e_en, o_en;

  logic [COL_W-1:0] a_col_r, b_col_r, c_col_r, d_col_r, e_col_r, o_col_r;
  logic [SHIFT_W-1:0] a_sh_r, b_sh_r, c_sh_r, d_sh_r;

  logic signed [ACC_W-1:0]  a_v_r, b_v_r;
  logic signed [WORD_W-1:0] a_sc_r;
  logic signed [ACC_W:0]    b_pl_r, pl_nxt;
  logic signed [ACC_W-1:0]  b_ph_r, ph_nxt;
  logic signed [PROD_W-1:0] c_prod_r, prod_nxt;
  logic signed [PROD_W-1:0] d_rnd_r, rnd_nxt, rnd_add;
  logic signed [PROD_W-1:0] e_shf_r, shf_nxt;
  logic signed [ACC_W-1:0]  o_val_r, val_nxt;

  logic [TBITS_W-1:0]       tbits;
  logic signed [ACC_W-1:0]  lo_b, hi_b;
  logic signed [PROD_W-1:0] lo_w, hi_w;

  assign o_en    = !o_vld_r || m_ready;
  assign e_en    = !e_vld_r || o_en;
  assign d_en    = !d_vld_r || e_en;
  assign c_en    = !c_vld_r || d_en;
  assign b_en    = !b_vld_r || c_en;
  assign a_en    = !a_vld_r || b_en;
  assign s_ready = a_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
      d_vld_r <= 1'b0;
      e_vld_r <= 1'b0;
      o_vld_r <= 1'b0;
    end else begin
      if (a_en) a_vld_r <= s_valid;
      if (b_en) b_vld_r <= a_vld_r;
      if (c_en) c_vld_r <= b_vld_r;
      if (d_en) d_vld_r <= c_vld_r;
      if (e_en) e_vld_r <= d_vld_r;
      if (o_en) o_vld_r <= e_vld_r;
    end
  end

  // Split the 64-bit value into an unsigned low half and a signed high half.
  always_comb begin
    pl_nxt = $signed({1'b0, a_v_r[WORD_W-1:0]}) * a_sc_r;
    ph_nxt = $signed(a_v_r[ACC_W-1:WORD_W]) * a_sc_r;
  end

  always_comb begin
    if (cfg.requant_enable) begin
      prod_nxt = $signed({{WORD_W{b_ph_r[ACC_W-1]}}, b_ph_r, {WORD_W{1'b0}}})
               + $signed({{(PROD_W-ACC_W-1){b_pl_r[ACC_W]}}, b_pl_r});
    end else begin
      prod_nxt = $signed({{(PROD_W-ACC_W){b_v_r[ACC_W-1]}}, b_v_r});
    end
  end

  always_comb begin
    rnd_add = '0;
    if (cfg.requant_enable && cfg.round_enable && (c_sh_r != '0)) begin
      rnd_add = $signed({{(PROD_W-1){1'b0}}, 1'b1} << (c_sh_r - 7'd1));
    end
    rnd_nxt = c_prod_r + rnd_add;
  end

  assign shf_nxt = d_rnd_r >>> d_sh_r;

  always_comb begin
    tbits = (cfg.tgt_width < 6'd2) ? 6'd2 : cfg.tgt_width;
    if (cfg.target_signed) begin
      hi_b = $signed((64'd1 << (tbits - 6'd1)) - 64'd1);
      lo_b = ~hi_b;
    end else begin
      hi_b = $signed((64'd1 << tbits) - 64'd1);
      lo_b = '0;
    end
    lo_w = $signed({{(PROD_W-ACC_W){lo_b[ACC_W-1]}}, lo_b});
    hi_w = $signed({{(PROD_W-ACC_W){hi_b[ACC_W-1]}}, hi_b});
    if (!cfg.requant_enable) begin
      val_nxt = e_shf_r[ACC_W-1:0];
    end else if (e_shf_r < lo_w) begin
      val_nxt = lo_b;
    end else if (e_shf_r > hi_w) begin
      val_nxt = hi_b;
    end else begin
      val_nxt = e_shf_r[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_en) begin
      a_col_r <= s_column;
      a_v_r   <= s_value;
      a_sc_r  <= s_scale;
      a_sh_r  <= cfg.requant_enable ? s_shift : '0;
    end
    if (b_en) begin
      b_col_r <= a_col_r;
      b_v_r   <= a_v_r;
      b_pl_r  <= pl_nxt;
      b_ph_r  <= ph_nxt;
      b_sh_r  <= a_sh_r;
    end
    if (c_en) begin
      c_col_r  <= b_col_r;
      c_prod_r <= prod_nxt;
      c_sh_r   <= b_sh_r;
    end
    if (d_en) begin
      d_col_r <= c_col_r;
      d_rnd_r <= rnd_nxt;
      d_sh_r  <= c_sh_r;
    end
    if (e_en) begin
      e_col_r <= d_col_r;
      e_shf_r <= shf_nxt;
    end
    if (o_en) begin
      o_col_r <= e_col_r;
      o_val_r <= val_nxt;
    end
  end

  assign m_valid  = o_vld_r;
  assign m_column = o_col_r;
  assign m_value  = o_val_r;

endmodule

### design/bias_requantize_output_stage_top.sv
// Top level of the bias add and integer requantize output stage.
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tdata: column, acc, bias, scale, shift; tuser: kind
// out_      master     out_tvalid/out_tready tdata: out_column, out_value
// cfg_      write      cfg_wr_en            cfg_index, cfg_wdata
//
// One transaction is taken per cycle while in_tready is high, data and table writes alike;
// a data item passes registers for the memory read, the bias stage, the split multiply,
// the product sum, the round add, the shifter and the clamp before it leaves.
// Table writes land in the parameter memory at acceptance and produce nothing.
// Reset clears the stage valids and loads config defaults; the tables are not cleared.
// A stall on the output backs up stage by stage, so bubbles close up first.

module bias_requantize_output_stage_top
  import brq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // column[5:0], acc_value[69:6], bias_word[101:70],
                                            // scale_word[133:102], shift_word[140:134], zero pad
  input  logic                  in_tuser,   // kind[0]
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // out_column[5:0], out_value[69:6], zero pad
  // Configuration write port
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;

  // Unpack the input transaction.
  logic [COL_W-1:0]         in_column;
  logic signed [ACC_W-1:0]  in_acc;
  entry_t                   in_entry;
  kind_t                    in_kind;
  logic                     in_fire;
  logic                     col_ok;

  assign in_column      = in_tdata[5:0];
  assign in_acc         = $signed(in_tdata[69:6]);
  assign in_entry.bias  = $signed(in_tdata[101:70]);
  assign in_entry.scale = $signed(in_tdata[133:102]);
  assign in_entry.shift = in_tdata[140:134];
  assign in_kind        = kind_t'(in_tuser);
  assign in_fire        = in_tvalid && in_tready;
  // Columns past the table drop on write and read as zero in per-column mode.
  assign col_ok         = (32'(in_column) < NUM_COLUMNS);

  // Hold config; the user must write only while the pipeline is empty, the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.bias_enable      <= 1'b0;
      cfg_r.requant_enable   <= 1'b0;
      cfg_r.round_enable     <= 1'b0;
      cfg_r.target_signed    <= 1'b1;
      cfg_r.tgt_width        <= 6'd8;
      cfg_r.bias_per_column  <= 1'b0;
      cfg_r.scale_per_column <= 1'b0;
      cfg_r.shift_per_column <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_BIAS_ENABLE:      cfg_r.bias_enable      <= cfg_wdata[0];
        REG_REQUANT_ENABLE:   cfg_r.requant_enable   <= cfg_wdata[0];
        REG_ROUND_ENABLE:     cfg_r.round_enable     <= cfg_wdata[0];
        REG_TARGET_SIGNED:    cfg_r.target_signed    <= cfg_wdata[0];
        REG_TGT_WIDTH:        cfg_r.tgt_width        <= cfg_wdata[TBITS_W-1:0];
        REG_BIAS_PER_COLUMN:  cfg_r.bias_per_column  <= cfg_wdata[0];
        REG_SCALE_PER_COLUMN: cfg_r.scale_per_column <= cfg_wdata[0];
        REG_SHIFT_PER_COLUMN: cfg_r.shift_per_column <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Parameter memory: write at acceptance, read at acceptance of a data item.
  logic   tbl_wr_en;
  logic   tbl_rd_en;
  entry_t tbl_rd_data;
  entry_t tbl_zero_data;

  assign tbl_wr_en = in_fire && (in_kind == KIND_WRITE) && col_ok;
  assign tbl_rd_en = in_fire && (in_kind == KIND_DATA);

  brq_table u_table (
    .clk       (clk),
    .wr_en     (tbl_wr_en),
    .wr_addr   (ADDR_W'(in_column)),
    .wr_data   (in_entry),
    .rd_en     (tbl_rd_en),
    .rd_addr   (ADDR_W'(in_column)),
    .rd_data   (tbl_rd_data),
    .zero_data (tbl_zero_data)
  );

  // Lookup stage: meta registers line up with the registered memory read.
  logic                    lk_vld_r;
  logic [COL_W-1:0]        lk_col_r;
  logic signed [ACC_W-1:0] lk_acc_r;
  logic                    lk_ok_r;
  logic                    lk_en;
  logic                    rq_ready;

  assign lk_en     = !lk_vld_r || rq_ready;
  assign in_tready = lk_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_vld_r <= 1'b0;
    end else if (lk_en) begin
      lk_vld_r <= tbl_rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_rd_en) begin
      lk_col_r <= in_column;
      lk_acc_r <= in_acc;
      lk_ok_r  <= col_ok;
    end
  end

  // Pick per-column or shared entries, then add bias with 64-bit saturation.
  logic signed [WORD_W-1:0] sel_bias;
  logic signed [WORD_W-1:0] sel_scale;
  logic [SHIFT_W-1:0]       sel_shift;
  logic signed [ACC_W:0]    bias_sum;
  logic signed [ACC_W-1:0]  biased;

  always_comb begin
    sel_bias  = cfg_r.bias_per_column  ? (lk_ok_r ? tbl_rd_data.bias  : '0)
                                       : tbl_zero_data.bias;
    sel_scale = cfg_r.scale_per_column ? (lk_ok_r ? tbl_rd_data.scale : '0)
                                       : tbl_zero_data.scale;
    sel_shift = cfg_r.shift_per_column ? (lk_ok_r ? tbl_rd_data.shift : '0)
                                       : tbl_zero_data.shift;
    bias_sum  = $signed({lk_acc_r[ACC_W-1], lk_acc_r})
              + $signed({{(ACC_W-WORD_W+1){sel_bias[WORD_W-1]}}, sel_bias});
    if (!cfg_r.bias_enable) begin
      biased = lk_acc_r;
    end else if (bias_sum[ACC_W] != bias_sum[ACC_W-1]) begin
      // Overflow: clamp toward the sign of the true sum.
      biased = bias_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      biased = bias_sum[ACC_W-1:0];
    end
  end

  logic [COL_W-1:0]        res_column;
  logic signed [ACC_W-1:0] res_value;

  brq_requant u_requant (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .s_valid  (lk_vld_r),
    .s_ready  (rq_ready),
    .s_column (lk_col_r),
    .s_value  (biased),
    .s_scale  (sel_scale),
    .s_shift  (sel_shift),
    .m_valid  (out_tvalid),
    .m_ready  (out_tready),
    .m_column (res_column),
    .m_value  (res_value)
  );

  assign out_tdata = {{(OUT_DATA_W-ACC_W-COL_W){1'b0}}, res_value, res_column};

endmodule
